@@ rtl/language_tag_parser_core_macros.svh @@
// Assertion macros for the language tag parser core.
// Used by the top level; expects clk and rst in the including scope.
`ifndef LANGUAGE_TAG_PARSER_CORE_MACROS_SVH
`define LANGUAGE_TAG_PARSER_CORE_MACROS_SVH

// Same-cycle implication, held off during reset
`define LTP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define LTP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ltp_pkg.sv @@
// Shared types, constants and byte helpers for the language tag parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package ltp_pkg;

  localparam int BUF_DEPTH        = 8;
  localparam int QUEUE_DEPTH      = 2;
  localparam int TAG_LIMIT_DEF    = 64;
  localparam int SUBTAG_LIMIT_DEF = 16;

  // Result kinds
  localparam logic [2:0] KIND_LANG   = 3'd0;
  localparam logic [2:0] KIND_SCRIPT = 3'd1;
  localparam logic [2:0] KIND_REGION = 3'd2;
  localparam logic [2:0] KIND_VAR    = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  // Case modes applied while draining a subtag
  localparam logic [1:0] MODE_LOWER = 2'd0;
  localparam logic [1:0] MODE_TITLE = 2'd1;
  localparam logic [1:0] MODE_UPPER = 2'd2;

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_H    = 8'h68;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_U    = 8'h75;

  // One unit of work handed from the front to the back
  typedef struct packed {
    logic                              emit;
    logic [3:0]                        len;
    logic [2:0]                        kind;
    logic [1:0]                        mode;
    logic [BUF_DEPTH-1:0][7:0]         bytes;
    logic                              status;
    logic                              valid;
    logic                              rtl;
  } job_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] c);
    return is_upper(c) ? (c + 8'd32) : c;
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] c);
    return is_lower(c) ? (c - 8'd32) : c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ltp_queue.sv @@
// Short job queue between the parser front and the drain back.
// Depends on ltp_pkg for job_t, q_stat_t and QUEUE_DEPTH.
`default_nettype none

module ltp_queue import ltp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire job_t    wr_job,
  input  wire logic    pop,
  output q_stat_t      q_stat,
  output job_t         head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t           slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign q_stat.full  = (count == CW'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ltp_front.sv @@
// Parser front: takes tag bytes, buffers the open subtag, gives each closed
// subtag its role and queues drain jobs. Depends on ltp_pkg.
`default_nettype none

module ltp_front import ltp_pkg::*; #(
  parameter int TAG_LIMIT    = TAG_LIMIT_DEF,
  parameter int SUBTAG_LIMIT = SUBTAG_LIMIT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] tag_byte,
  input  wire logic       final_byte,
  output logic            in_stall,
  input  wire q_stat_t    q_stat,
  output logic            push,
  output job_t            job
);

  logic [BUF_DEPTH-1:0][7:0] buffer;
  logic [3:0]                sub_len;
  logic [7:0]                tag_len;
  logic [2:0]                sub_num;
  logic                      letters;
  logic                      alnum;
  logic                      three_dig;
  logic                      region_taken;
  logic                      variant_taken;
  logic                      failed;
  logic                      rtl_lang;

  logic                      accept;
  logic                      is_dash;
  logic                      closing;
  logic [BUF_DEPTH-1:0][7:0] buf_upd;
  logic [3:0]                len_upd;
  logic [7:0]                tag_len_upd;
  logic                      letters_upd;
  logic                      alnum_upd;
  logic                      three_upd;
  logic                      fail_pre;
  logic                      fail_post;
  logic                      region_post;
  logic                      variant_post;
  logic                      rtl_post;
  logic                      emit;
  logic [2:0]                kind;
  logic [1:0]                mode;
  logic [7:0]                low0;
  logic [7:0]                low1;
  logic                      rtl_match;

  assign accept   = in_valid && !q_stat.full;
  assign in_stall = q_stat.full;
  assign is_dash  = (tag_byte == CH_DASH);
  assign closing  = is_dash || final_byte;

  // Fold the incoming byte into the open subtag
  always_comb begin
    buf_upd     = buffer;
    len_upd     = sub_len;
    letters_upd = letters;
    alnum_upd   = alnum;
    three_upd   = three_dig;
    tag_len_upd = (tag_len != 8'hFF) ? tag_len + 8'd1 : tag_len;
    fail_pre    = failed || (tag_len_upd >= 8'(TAG_LIMIT));
    if (!is_dash) begin
      if (sub_len < 4'(BUF_DEPTH)) begin
        buf_upd[sub_len[2:0]] = tag_byte;
      end
      if (!is_letter(tag_byte)) begin
        letters_upd = 1'b0;
      end
      if (!is_letter(tag_byte) && !is_numeral(tag_byte)) begin
        alnum_upd = 1'b0;
      end
      if ((sub_len < 4'd3) && !is_numeral(tag_byte)) begin
        three_upd = 1'b0;
      end
      if (sub_len != 4'hF) begin
        len_upd = sub_len + 4'd1;
      end
    end
  end

  // Right-to-left language check on a two-letter language subtag
  assign low0      = to_low(buf_upd[0]);
  assign low1      = to_low(buf_upd[1]);
  assign rtl_match = ((low0 == CH_A) && (low1 == CH_R)) ||
                     ((low0 == CH_H) && (low1 == CH_E)) ||
                     ((low0 == CH_F) && (low1 == CH_A)) ||
                     ((low0 == CH_U) && (low1 == CH_R));

  // Give the closing subtag its role, in order of trial
  always_comb begin
    fail_post    = fail_pre;
    region_post  = region_taken;
    variant_post = variant_taken;
    rtl_post     = rtl_lang;
    emit         = 1'b0;
    kind         = KIND_LANG;
    mode         = MODE_LOWER;
    if (!fail_pre) begin
      priority if ((len_upd == 4'd0) || ({3'b0, len_upd} >= 7'(SUBTAG_LIMIT)) ||
                   (len_upd > 4'(BUF_DEPTH))) begin
        fail_post = 1'b1;
      end else if (sub_num == 3'd0) begin
        if ((len_upd >= 4'd2) && letters_upd) begin
          emit = 1'b1;
          if (len_upd == 4'd2) begin
            rtl_post = rtl_match;
          end
        end else begin
          fail_post = 1'b1;
        end
      end else if ((sub_num == 3'd1) && (len_upd == 4'd4) && letters_upd) begin
        emit = 1'b1;
        kind = KIND_SCRIPT;
        mode = MODE_TITLE;
      end else if (((sub_num == 3'd1) || (sub_num == 3'd2)) && !region_taken &&
                   (((len_upd == 4'd2) && letters_upd) ||
                    ((len_upd == 4'd3) && three_upd))) begin
        emit        = 1'b1;
        region_post = 1'b1;
        kind        = KIND_REGION;
        mode        = (len_upd == 4'd2) ? MODE_UPPER : MODE_LOWER;
      end else if (!variant_taken && (len_upd >= 4'd4) && alnum_upd) begin
        emit         = 1'b1;
        variant_post = 1'b1;
        kind         = KIND_VAR;
      end else begin
        fail_post = 1'b1;
      end
    end
  end

  // Queue a job for each emitted subtag and for each tag end
  assign push       = accept && ((closing && emit) || final_byte);
  assign job.emit   = closing && emit;
  assign job.len    = len_upd;
  assign job.kind   = kind;
  assign job.mode   = mode;
  assign job.bytes  = buf_upd;
  assign job.status = final_byte;
  assign job.valid  = !fail_post;
  assign job.rtl    = !fail_post && rtl_post;

  // Hold subtag bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      buffer <= buf_upd;
    end
  end

  // Advance parse state; a final byte returns it to reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_len       <= '0;
      tag_len       <= '0;
      sub_num       <= '0;
      letters       <= 1'b1;
      alnum         <= 1'b1;
      three_dig     <= 1'b1;
      region_taken  <= 1'b0;
      variant_taken <= 1'b0;
      failed        <= 1'b0;
      rtl_lang      <= 1'b0;
    end else if (accept) begin
      if (final_byte) begin
        sub_len       <= '0;
        tag_len       <= '0;
        sub_num       <= '0;
        letters       <= 1'b1;
        alnum         <= 1'b1;
        three_dig     <= 1'b1;
        region_taken  <= 1'b0;
        variant_taken <= 1'b0;
        failed        <= 1'b0;
        rtl_lang      <= 1'b0;
      end else if (is_dash) begin
        sub_len       <= '0;
        tag_len       <= tag_len_upd;
        sub_num       <= (sub_num != 3'd7) ? sub_num + 3'd1 : sub_num;
        letters       <= 1'b1;
        alnum         <= 1'b1;
        three_dig     <= 1'b1;
        region_taken  <= region_post;
        variant_taken <= variant_post;
        failed        <= fail_post;
        rtl_lang      <= rtl_post;
      end else begin
        sub_len   <= len_upd;
        tag_len   <= tag_len_upd;
        letters   <= letters_upd;
        alnum     <= alnum_upd;
        three_dig <= three_upd;
        failed    <= fail_pre;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ltp_back.sv @@
// Drain back: walks each queued job, emits normalized subtag bytes and the
// status item into a registered output stage. Depends on ltp_pkg.
`default_nettype none

module ltp_back import ltp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_stat_t q_stat,
  input  wire job_t    head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output logic [7:0]   norm_byte,
  output logic [2:0]   part_kind,
  output logic         subtag_end,
  output logic         tag_valid,
  output logic         right_to_left,
  output logic         tag_done
);

  logic [3:0] pos;
  logic       load;
  logic [3:0] n_bytes;
  logic       in_bytes;
  logic       last;
  logic [7:0] raw;
  logic       make_up;
  logic [7:0] cased;

  assign load     = !q_stat.empty && (!out_valid || !out_stall);
  assign n_bytes  = head.emit ? head.len : 4'd0;
  assign in_bytes = (pos < n_bytes);
  assign last     = in_bytes ? ((pos + 4'd1 == n_bytes) && !head.status) : 1'b1;
  assign pop      = load && last;

  // Normalize the byte under the drain position
  assign raw     = head.bytes[pos[2:0]];
  assign make_up = (head.mode == MODE_UPPER) || ((head.mode == MODE_TITLE) && (pos == 4'd0));
  assign cased   = make_up ? to_up(raw) : to_low(raw);

  // Advance drain position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= last ? 4'd0 : pos + 4'd1;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (in_bytes) begin
        norm_byte     <= cased;
        part_kind     <= head.kind;
        subtag_end    <= (pos + 4'd1 == n_bytes);
        tag_valid     <= 1'b0;
        right_to_left <= 1'b0;
        tag_done      <= 1'b0;
      end else begin
        norm_byte     <= 8'd0;
        part_kind     <= KIND_STATUS;
        subtag_end    <= 1'b0;
        tag_valid     <= head.valid;
        right_to_left <= head.rtl;
        tag_done      <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/language_tag_parser_core.sv @@
// Top level of the language tag parser: front, job queue and drain back.
// Depends on ltp_pkg, ltp_front, ltp_queue, ltp_back and the macros header.
//
//   channel  | signals                                            | flow
//   ---------+----------------------------------------------------+---------
//   in       | in_valid, in_stall, tag_byte, final_byte           | to block
//   out      | out_valid, out_stall, norm_byte, part_kind,        | from
//            | subtag_end, tag_valid, right_to_left, tag_done     | block
//
// The front takes one tag byte per cycle while the two-entry job queue has room.
// The back moves one result per cycle into the output register while the queue
// holds a job and out_stall is low: each byte of an emitted subtag, then the
// status item at a tag end; the drain of the back sets the sustained rate.
// Reset clears all control state; no clearing pass is needed.
// out_stall holds the output word; the queue then fills and in_stall rises.
`default_nettype none
`include "language_tag_parser_core_macros.svh"

module language_tag_parser_core import ltp_pkg::*; #(
  parameter int TAG_LIMIT    = TAG_LIMIT_DEF,
  parameter int SUBTAG_LIMIT = SUBTAG_LIMIT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] tag_byte,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      norm_byte,
  output logic [2:0]      part_kind,
  output logic            subtag_end,
  output logic            tag_valid,
  output logic            right_to_left,
  output logic            tag_done
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    wr_job;
  job_t    head;

  ltp_front #(
    .TAG_LIMIT    (TAG_LIMIT),
    .SUBTAG_LIMIT (SUBTAG_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .tag_byte   (tag_byte),
    .final_byte (final_byte),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .push       (push),
    .job        (wr_job)
  );

  ltp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  ltp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .norm_byte     (norm_byte),
    .part_kind     (part_kind),
    .subtag_end    (subtag_end),
    .tag_valid     (tag_valid),
    .right_to_left (right_to_left),
    .tag_done      (tag_done)
  );

  // Status items carry no byte and close no subtag
  `LTP_ASSERT_NOW(a_status_shape, out_valid && tag_done, (norm_byte == 8'd0) && !subtag_end && (part_kind == KIND_STATUS), "status item malformed")

  // Byte items carry no status
  `LTP_ASSERT_NOW(a_byte_shape, out_valid && !tag_done, !tag_valid && !right_to_left && (part_kind != KIND_STATUS), "byte item carries status")

  // Right-to-left is reported only for a valid tag
  `LTP_ASSERT_NOW(a_rtl_valid, out_valid && right_to_left, tag_valid, "rtl on invalid tag")

  // The back only drains a queue that holds a job
  `LTP_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

  // Every push lands in a queue that had a free slot
  `LTP_ASSERT_NEXT(a_push_room, push, !$past(q_stat.full), "push into full queue")

endmodule

`default_nettype wire
